FILE: rtl/core/swam_pkg.sv
// Shared constants, types and helper functions of the sliding window activity meter.
package swam_pkg;

	localparam int HIST_DEPTH = 65536;
	localparam int POS_W      = $clog2(HIST_DEPTH);
	localparam int FILL_W     = POS_W + 1;
	localparam int WIN_W      = 17;
	localparam int CNT_W      = 17;
	localparam int PCT_W      = 15;
	localparam int PROD_W     = 32;
	localparam int QUO_W      = 16;
	localparam int STEP_W     = $clog2(QUO_W);
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;

	localparam logic [PCT_W-1:0] PCT_SCALE  = PCT_W'(25600);
	localparam logic [WIN_W-1:0] WIN_RESET  = WIN_W'(3600);
	localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

	// Register index of the window size register.
	localparam logic REG_WINDOW = 1'b0;

	// Window clamped into 1 .. HIST_DEPTH.
	function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
		logic [WIN_W-1:0] r;
		r = w;
		if (w == '0) begin
			r = WIN_W'(1);
		end else if (32'(w) > 32'(HIST_DEPTH)) begin
			r = WIN_W'(HIST_DEPTH);
		end
		return r;
	endfunction

	// Leave position right after a restart: depth minus window, modulo depth.
	function automatic logic [POS_W-1:0] leave_start(input logic [WIN_W-1:0] weff);
		logic [31:0] d;
		d = 32'(HIST_DEPTH) - 32'(weff);
		return d[POS_W-1:0];
	endfunction

	localparam logic [POS_W-1:0] LEAVE_RESET = leave_start(eff_window(WIN_RESET));

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INC  = 2'd1,
		OP_DEC  = 2'd2
	} op_t;

	typedef struct packed {
		logic             restart;
		logic [WIN_W-1:0] weff;
	} cfg_t;

endpackage

FILE: rtl/core/swam_front.sv
// Front end: takes ticks, keeps the bit history and classifies each tick into a count update.
module swam_front (
	input  logic               clk,
	input  logic               arst_n,
	input  swam_pkg::cfg_t     cfg,
	input  logic               push,
	input  logic               active,
	output logic               full,
	output logic               opq_push,
	output swam_pkg::op_t      opq_op,
	input  logic               opq_full
);
	import swam_pkg::*;

	logic              mem [HIST_DEPTH];
	logic [POS_W-1:0]  write_pos_q;
	logic [POS_W-1:0]  leave_pos_q;
	logic [FILL_W-1:0] fill_q;
	logic              vld_s1;
	logic              act_s1;
	logic              lvalid_s1;
	logic              rd_s1;
	logic              accept;
	logic              leaving;

	assign full     = vld_s1 | opq_full | cfg.restart;
	assign accept   = push & ~full;
	assign opq_push = vld_s1 & ~opq_full;

	// Entries beyond the fill count were never written since the restart and read as zero.
	assign leaving = rd_s1 & lvalid_s1;

	always_comb begin
		opq_op = OP_HOLD;
		if (act_s1 && !leaving) begin
			opq_op = OP_INC;
		end else if (!act_s1 && leaving) begin
			opq_op = OP_DEC;
		end
	end

	// History memory: read of the leaving bit comes before the write of the new one.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1            <= mem[leave_pos_q];
			mem[write_pos_q] <= active;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= active;
			lvalid_s1 <= ({1'b0, leave_pos_q} < fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			leave_pos_q <= LEAVE_RESET;
			fill_q      <= '0;
			vld_s1      <= 1'b0;
		end else if (cfg.restart) begin
			write_pos_q <= '0;
			leave_pos_q <= leave_start(cfg.weff);
			fill_q      <= '0;
			vld_s1      <= 1'b0;
		end else begin
			if (accept) begin
				write_pos_q <= write_pos_q + POS_W'(1);
				leave_pos_q <= leave_pos_q + POS_W'(1);
				if (fill_q != FILL_W'(HIST_DEPTH)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				vld_s1 <= 1'b1;
			end else if (opq_push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/swam_opq.sv
// Two-entry queue of count updates between the front end and the back end.
module swam_opq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swam_pkg::op_t op_in,
	output logic          full,
	input  logic          pop,
	output swam_pkg::op_t op_out,
	output logic          empty
);
	import swam_pkg::*;

	op_t        slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign op_out  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

FILE: rtl/core/swam_back.sv
// Back end: running count, percentage by multiply and bit-serial divide, and result queue.
module swam_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swam_pkg::cfg_t                cfg,
	input  logic                          opq_empty,
	input  swam_pkg::op_t                 opq_op,
	output logic                          opq_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [swam_pkg::CNT_W-1:0]    active_count,
	output logic [swam_pkg::PCT_W-1:0]    percent_q8
);
	import swam_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [PROD_W-1:0]   prod_q;
	logic [WIN_W-1:0]    rem_q;
	logic [QUO_W-1:0]    dvd_q;
	logic [QUO_W-1:0]    quo_q;
	logic [STEP_W-1:0]   step_q;
	logic [WIN_W:0]      trial;
	logic                ge;
	logic [PCT_W-1:0]    pct;

	logic [CNT_W-1:0]    oq_cnt_q [2];
	logic [PCT_W-1:0]    oq_pct_q [2];
	logic                owptr_q;
	logic                orptr_q;
	logic [1:0]          ocnt_q;
	logic                out_push;
	logic                out_pop;

	assign opq_pop = (state_q == ST_IDLE) & ~opq_empty & ~cfg.restart;

	// One restoring step: shift in the next dividend bit and try the divisor.
	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign ge    = (trial >= {1'b0, cfg.weff});
	assign pct   = (quo_q > QUO_W'(PCT_SCALE)) ? PCT_SCALE : quo_q[PCT_W-1:0];

	assign out_push     = (state_q == ST_OUT) & (ocnt_q != 2'd2);
	assign out_pop      = pop & ~empty;
	assign empty        = (ocnt_q == 2'd0);
	assign active_count = oq_cnt_q[orptr_q];
	assign percent_q8   = oq_pct_q[orptr_q];

	always_ff @(posedge clk) begin
		if (out_push) begin
			oq_cnt_q[owptr_q] <= count_q;
			oq_pct_q[owptr_q] <= pct;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			prod_q  <= '0;
			rem_q   <= '0;
			dvd_q   <= '0;
			quo_q   <= '0;
			step_q  <= '0;
		end else if (cfg.restart) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (opq_pop) begin
						unique case (opq_op)
							OP_INC: begin
								if (count_q != CNT_MAX) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_DEC: begin
								if (count_q != '0) begin
									count_q <= count_q - CNT_W'(1);
								end
							end
							default: ;
						endcase
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(count_q) * PROD_W'(PCT_SCALE);
					state_q <= ST_DINIT;
				end
				ST_DINIT: begin
					if ({1'b0, prod_q[PROD_W-1:QUO_W]} >= cfg.weff) begin
						// Quotient would not fit; it saturates at full scale.
						quo_q   <= {QUO_W{1'b1}};
						state_q <= ST_OUT;
					end else begin
						rem_q   <= {1'b0, prod_q[PROD_W-1:QUO_W]};
						dvd_q   <= prod_q[QUO_W-1:0];
						quo_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= ge ? WIN_W'(trial - {1'b0, cfg.weff}) : trial[WIN_W-1:0];
					dvd_q  <= {dvd_q[QUO_W-2:0], 1'b0};
					quo_q  <= {quo_q[QUO_W-2:0], ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(QUO_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			if (out_push) begin
				owptr_q <= ~owptr_q;
			end
			if (out_pop) begin
				orptr_q <= ~orptr_q;
			end
			ocnt_q <= ocnt_q + 2'(out_push) - 2'(out_pop);
		end
	end

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result queue count out of range");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < cfg.weff))
		else $error("divider remainder not below divisor");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(cfg.restart) && (count_q != $past(count_q))) |->
		((count_q == CNT_W'($past(count_q) + CNT_W'(1))) ||
		 (count_q == CNT_W'($past(count_q) - CNT_W'(1)))))
		else $error("active count moved by more than one");

endmodule

FILE: rtl/core/sliding_window_activity_meter.sv
// Top level of the sliding window activity meter: configuration register and block wiring.
//
// The meter takes one beat per tick on the input queue (push/full, field active) and
// returns one result beat per tick on the output queue (empty/pop, fields active_count
// and percent_q8). active_count is the number of active ticks among the last
// window_size ticks; percent_q8 is floor(active_count * 25600 / window) in Q8 percent.
// The window lives in a single APB register at byte address 0; a write there restarts
// the measurement: history, count and positions start over, as after reset.
// A tick passes through the front end (history read, then the update is classified),
// waits in a two-entry queue, and then the back end works on it: count update, one
// multiply, a 16-step bit-serial divide (skipped when the quotient saturates) and the
// write into a two-entry result queue. The back end takes no new tick until it has
// written the result of the last one, and the front end holds one tick at a time.
// The history needs no clearing pass: a fill count marks which entries were written
// since the last restart, so the block takes ticks right after reset; after a
// configuration write, full stays high for one cycle while both halves restart.
// When the receiver stalls, results collect in the result queue, the back end then
// stops, and finally full rises on the input side.
module sliding_window_activity_meter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                active,
	output logic                                empty,
	input  logic                                pop,
	output logic [swam_pkg::CNT_W-1:0]          active_count,
	output logic [swam_pkg::PCT_W-1:0]          percent_q8,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swam_pkg::ADDR_W-1:0]         paddr,
	input  logic [swam_pkg::DATA_W-1:0]         pwdata,
	output logic [swam_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);
	import swam_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic             restart_q;
	logic             reg_wr;
	cfg_t             cfg;
	logic             opq_push;
	op_t              opq_in;
	logic             opq_full;
	logic             opq_pop;
	op_t              opq_out;
	logic             opq_empty;

	// The register index is the word address; writes to other words are dropped.
	assign pready = 1'b1;
	assign reg_wr = psel & penable & pwrite & pready & (paddr[ADDR_W-1] == REG_WINDOW);
	assign prdata = (paddr[ADDR_W-1] == REG_WINDOW) ? DATA_W'(window_q) : '0;

	// The restart is applied in the cycle after the write, so that both halves see the
	// new window when they rebuild their state.
	assign cfg.restart = restart_q;
	assign cfg.weff    = eff_window(window_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WIN_RESET;
			restart_q <= 1'b0;
		end else begin
			restart_q <= reg_wr;
			if (reg_wr) begin
				window_q <= pwdata[WIN_W-1:0];
			end
		end
	end

	swam_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.push     (push),
		.active   (active),
		.full     (full),
		.opq_push (opq_push),
		.opq_op   (opq_in),
		.opq_full (opq_full)
	);

	swam_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (opq_push),
		.op_in  (opq_in),
		.full   (opq_full),
		.pop    (opq_pop),
		.op_out (opq_out),
		.empty  (opq_empty)
	);

	swam_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.opq_empty    (opq_empty),
		.opq_op       (opq_out),
		.opq_pop      (opq_pop),
		.empty        (empty),
		.pop          (pop),
		.active_count (active_count),
		.percent_q8   (percent_q8)
	);

endmodule
